/* design/rgbhsl_pkg.sv */
// Package for the RGB to HSL converter: widths, constants and the item
// formats passed between the front end, the queue and the back end.
// No dependencies.
package rgbhsl_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_W       = 16;
  localparam int QUO_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Hue sector offsets on the 255-step circle.
  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

  // Hue steps per sixth of the circle, and the scale constants.
  localparam logic [7:0] HUE_STEP      = 8'd43;
  localparam logic [8:0] HUE_WRAP      = 9'd255;
  localparam logic [8:0] DOUBLE_SCALE  = 9'd510;
  localparam logic [8:0] LIGHT_HALF    = 9'd256;

  // Classified pixel, ready for the two divisions.
  typedef struct packed {
    logic             gray;
    logic             hue_neg;
    logic [7:0]       hue_base;
    logic [7:0]       lightness;
    logic [NUM_W-1:0] sat_num;
    logic [7:0]       sat_den;
    logic [NUM_W-1:0] hue_num;
    logic [7:0]       hue_den;
  } work_t;

  // Fields that ride alongside the divider pipeline.
  typedef struct packed {
    logic       gray;
    logic       hue_neg;
    logic [7:0] hue_base;
    logic [7:0] lightness;
  } side_t;

endpackage

/* design/rgbhsl_if.sv */
// Handshake interfaces for the pixel input and the HSL result channels.
// No dependencies.
interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsl_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                output ready);
endinterface

/* design/rgb_to_hsl_8bit_top.sv */
// Top level of the RGB to HSL converter. Depends on rgbhsl_pkg, rgb_if,
// hsl_if, rgbhsl_front, rgbhsl_queue and rgbhsl_back.
//
// Converts one 8-bit RGB pixel per clock cycle into hue (255-step circle,
// red at 0), saturation and lightness, as long as the result side is ready.
// Each pixel passes through the front-end register, the four-entry queue,
// the bit-per-stage divider pipelines for saturation and hue, and the
// output register. The queue lets the input keep taking pixels while the
// result side stalls, until it fills.
module rgb_to_hsl_8bit_top (
  input  logic clk,
  input  logic rst,
  rgb_if.sink  pixel,
  hsl_if.source result
);
  import rgbhsl_pkg::*;

  logic  fq_valid;
  logic  fq_ready;
  work_t fq_item;
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_item;

  rgbhsl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  rgbhsl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  rgbhsl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_item  (qb_item),
    .result  (result)
  );

endmodule

/* design/rgbhsl_front.sv */
// Front end: accepts pixels, finds max and min, and prepares the numerators,
// divisors and hue sector for the back end. Depends on rgbhsl_pkg, rgb_if.
module rgbhsl_front (
  input  logic              clk,
  input  logic              rst,
  rgb_if.sink               pixel,
  output logic              q_valid,
  input  logic              q_ready,
  output rgbhsl_pkg::work_t q_item
);
  import rgbhsl_pkg::*;

  logic        held_valid;
  work_t       held_item;
  work_t       item_next;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [8:0]  sum;
  logic [8:0]  diff;
  logic [8:0]  diff_abs;

  // Classify the pixel: extremes, lightness, divisors and hue sector.
  always_comb begin
    mx = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};

    if (mx == pixel.red) begin
      item_next.hue_base = HUE_BASE_RED;
      diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
    end else if (mx == pixel.green) begin
      item_next.hue_base = HUE_BASE_GREEN;
      diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
    end else begin
      item_next.hue_base = HUE_BASE_BLUE;
      diff = {1'b0, pixel.red} - {1'b0, pixel.green};
    end
    diff_abs = diff[8] ? (9'd0 - diff) : diff;

    item_next.gray      = (delta == 8'd0);
    item_next.hue_neg   = diff[8];
    item_next.lightness = sum[8:1];
    item_next.sat_num   = {delta, 8'd0} - {8'd0, delta};
    item_next.sat_den   = (sum < LIGHT_HALF) ? sum[7:0] : 8'(DOUBLE_SCALE - sum);
    item_next.hue_num   = {7'd0, diff_abs} * {8'd0, HUE_STEP};
    item_next.hue_den   = delta;
  end

  // Holding register in front of the queue.
  assign pixel.ready = !held_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pixel.valid && pixel.ready) begin
      held_valid <= 1'b1;
    end else if (q_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      held_item <= item_next;
    end
  end

  assign q_valid = held_valid;
  assign q_item  = held_item;

endmodule

/* design/rgbhsl_queue.sv */
// Short queue between the front end and the back end, so that each side
// can stall on its own. Depends on rgbhsl_pkg.
module rgbhsl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  rgbhsl_pkg::work_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output rgbhsl_pkg::work_t rd_item
);
  import rgbhsl_pkg::*;

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

/* design/rgbhsl_div.sv */
// Pipelined restoring divider: one quotient bit per stage, eight stages.
// The quotient must fit in eight bits. Depends on rgbhsl_pkg.
module rgbhsl_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rgbhsl_pkg::NUM_W-1:0] num,
  input  logic [7:0]                   den,
  output logic [rgbhsl_pkg::QUO_W-1:0] quo
);
  import rgbhsl_pkg::*;

  logic [NUM_W-1:0] rem_q   [QUO_W-1];
  logic [7:0]       dv_q    [QUO_W-1];
  logic [QUO_W-1:0] qt_q    [QUO_W];
  logic [NUM_W-1:0] rem_in  [QUO_W];
  logic [7:0]       den_in  [QUO_W];
  logic [QUO_W-1:0] quo_in  [QUO_W];
  logic [NUM_W:0]   trial   [QUO_W];
  logic [NUM_W-1:0] rem_out [QUO_W];
  logic [QUO_W-1:0] quo_out [QUO_W];

  // Each stage tries to subtract the divisor shifted to its quotient bit.
  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k] = rem_q[k-1];
      den_in[k] = dv_q[k-1];
      quo_in[k] = qt_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {1'b0, rem_in[k]} -
                 {1'b0, NUM_W'({8'd0, den_in[k]} << (QUO_W - 1 - k))};
      if (!trial[k][NUM_W]) begin
        rem_out[k] = trial[k][NUM_W-1:0];
        quo_out[k] = quo_in[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem_out[k] = rem_in[k];
        quo_out[k] = quo_in[k];
      end
    end
  end

  // Stage registers; the last stage only needs its quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W - 1; k++) begin
        rem_q[k] <= rem_out[k];
        dv_q[k]  <= den_in[k];
      end
      for (int k = 0; k < QUO_W; k++) begin
        qt_q[k] <= quo_out[k];
      end
    end
  end

  assign quo = qt_q[QUO_W-1];

endmodule

/* design/rgbhsl_back.sv */
// Back end: runs the saturation and hue divisions in lock-step pipelines and
// assembles the result in an output register. Depends on rgbhsl_pkg,
// rgbhsl_div, hsl_if.
module rgbhsl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  rgbhsl_pkg::work_t q_item,
  hsl_if.source             result
);
  import rgbhsl_pkg::*;

  logic             en;
  logic             stage_valid [QUO_W];
  side_t            side        [QUO_W];
  logic [QUO_W-1:0] sat_quo;
  logic [QUO_W-1:0] hue_quo;
  logic             out_valid;
  logic [7:0]       out_hue;
  logic [7:0]       out_sat;
  logic [7:0]       out_light;
  logic [8:0]       hue_sum;
  logic [7:0]       hue_next;

  // The whole back end advances unless a finished result is waiting.
  assign en      = !out_valid || result.ready;
  assign q_ready = en;

  rgbhsl_div u_sat_div (
    .clk (clk),
    .en  (en),
    .num (q_item.sat_num),
    .den (q_item.sat_den),
    .quo (sat_quo)
  );

  rgbhsl_div u_hue_div (
    .clk (clk),
    .en  (en),
    .num (q_item.hue_num),
    .den (q_item.hue_den),
    .quo (hue_quo)
  );

  // Valid bits and side fields travel alongside the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUO_W; i++) stage_valid[i] <= 1'b0;
    end else if (en) begin
      stage_valid[0] <= q_valid;
      for (int i = 1; i < QUO_W; i++) stage_valid[i] <= stage_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{gray: q_item.gray, hue_neg: q_item.hue_neg,
                   hue_base: q_item.hue_base, lightness: q_item.lightness};
      for (int i = 1; i < QUO_W; i++) side[i] <= side[i-1];
    end
  end

  // Apply the sign of the hue offset and wrap a negative hue onto the circle.
  always_comb begin
    if (side[QUO_W-1].hue_neg) begin
      hue_sum = {1'b0, side[QUO_W-1].hue_base} - {1'b0, hue_quo};
    end else begin
      hue_sum = {1'b0, side[QUO_W-1].hue_base} + {1'b0, hue_quo};
    end
    if (hue_sum[8]) begin
      hue_sum = hue_sum + HUE_WRAP;
    end
    hue_next = hue_sum[7:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stage_valid[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hue   <= side[QUO_W-1].gray ? 8'd0 : hue_next;
      out_sat   <= side[QUO_W-1].gray ? 8'd0 : sat_quo;
      out_light <= side[QUO_W-1].lightness;
    end
  end

  assign result.valid      = out_valid;
  assign result.hue        = out_hue;
  assign result.saturation = out_sat;
  assign result.lightness  = out_light;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the RGB to HSL converter: a directed table of pixels,
// then random pixels in four idling phases, checked by typed rows or a local model.
// Depends on rgbhsl_pkg, rgb_if, hsl_if and rgb_to_hsl_8bit_top.
module testbench;
  import rgbhsl_pkg::*;

  // One converted pixel, in the order the result channel carries it.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
  } hsl_pix_t;

  // One row of the directed table; known marks rows whose result is typed in.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    hsl_pix_t   hsl;
  } pixel_row_t;

  localparam int NUM_ROWS      = 24;
  localparam int RANDOM_PIXELS = 1330;
  localparam int NUM_PHASES    = 4;
  localparam int DRAIN_CYCLES  = 24;

  logic clk;
  logic rst;

  rgb_if pixel ();
  hsl_if result ();

  rgb_to_hsl_8bit_top uut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result)
  );

  hsl_pix_t pending_hsl [$];
  int       gap_pct;
  int       stall_pct;
  int       error_count;
  int       pixels_sent;
  int       results_checked;
  int       gray_sent;

  pixel_row_t pixel_rows [NUM_ROWS] = '{
    // Gray pixels at the extremes and mid scale.
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
    // Pure primaries and secondaries; ties go to red, then green.
    '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd127}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd127}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd171, 8'd255, 8'd127}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd43,  8'd255, 8'd127}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd128, 8'd255, 8'd127}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd212, 8'd255, 8'd127}},
    // Smallest difference at the dark and the bright end.
    '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd0}},
    '{8'd255, 8'd254, 8'd254, 1'b1, '{8'd0,   8'd255, 8'd254}},
    // Remaining rows are checked against the model.
    '{8'd255, 8'd1,   8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd1,   8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd0,   8'd255, 8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd200, 8'd100, 8'd150, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd255, 8'd255, 8'd254, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd127, 8'd128, 8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'haa,  8'h55,  8'haa,  1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'h55,  8'haa,  8'h55,  1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd128, 8'd127, 8'd127, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd0,   8'd1,   8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd254, 8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{8'd10,  8'd200, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}}
  };

  // Clock with a period of ten time units.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Works out hue, saturation and lightness of one pixel.
  function automatic hsl_pix_t rgb_to_hsl(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    int       top;
    int       bottom;
    int       span;
    int       total;
    int       divisor;
    int       sector;
    int       slope;
    int       angle;
    hsl_pix_t conv;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span  = top - bottom;
    total = top + bottom;
    conv.lightness  = 8'(total / 2);
    conv.hue        = 8'd0;
    conv.saturation = 8'd0;
    if (span != 0) begin
      divisor = (total / 2 < 128) ? total : int'(DOUBLE_SCALE) - total;
      conv.saturation = 8'((span * int'(HUE_WRAP)) / divisor);
      // The first component that equals the maximum picks the sector.
      if (top == r) begin
        sector = int'(HUE_BASE_RED);
        slope  = int'(g) - int'(b);
      end else if (top == g) begin
        sector = int'(HUE_BASE_GREEN);
        slope  = int'(b) - int'(r);
      end else begin
        sector = int'(HUE_BASE_BLUE);
        slope  = int'(r) - int'(g);
      end
      // Signed division truncates toward zero, as the block must.
      angle = sector + (int'(HUE_STEP) * slope) / span;
      if (angle < 0) angle += int'(HUE_WRAP);
      conv.hue = 8'(angle);
    end
    return conv;
  endfunction

  // Offers one pixel after a random gap and records what it should become.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic known, input hsl_pix_t typed);
    while ($urandom_range(99) < gap_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.red   <= r;
    pixel.green <= g;
    pixel.blue  <= b;
    do @(posedge clk); while (!pixel.ready);
    pending_hsl.push_back(known ? typed : rgb_to_hsl(r, g, b));
    pixels_sent++;
    if (r == g && g == b) gray_sent++;
  endtask

  // Draws a pixel, leaning towards grays, ties, small differences and extremes.
  task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    logic [7:0] edges [6];
    logic [7:0] centre;
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        centre = 8'($urandom_range(3, 252));
        r = centre + 8'($urandom_range(6)) - 8'd3;
        g = centre + 8'($urandom_range(6)) - 8'd3;
        b = centre + 8'($urandom_range(6)) - 8'd3;
      end
      3: begin
        r = edges[$urandom_range(5)];
        g = edges[$urandom_range(5)];
        b = edges[$urandom_range(5)];
      end
      default: ;
    endcase
  endtask

  // Result side stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    hsl_pix_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_hsl.size() == 0) begin
        $display("%0t: unexpected result hue %0d sat %0d light %0d", $time,
                 result.hue, result.saturation, result.lightness);
        error_count++;
      end else begin
        want = pending_hsl.pop_front();
        results_checked++;
        if (result.hue !== want.hue) begin
          $display("%0t: hue expected %0d, got %0d", $time, want.hue, result.hue);
          error_count++;
        end
        if (result.saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d, got %0d", $time, want.saturation,
                   result.saturation);
          error_count++;
        end
        if (result.lightness !== want.lightness) begin
          $display("%0t: lightness expected %0d, got %0d", $time, want.lightness,
                   result.lightness);
          error_count++;
        end
      end
    end
  end

  // Stimulus: the directed table, then random pixels in four idling phases.
  initial begin : stimulus
    int         phase_gap [NUM_PHASES];
    int         phase_stall [NUM_PHASES];
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    phase_gap   = '{0, 64, 0, 12};
    phase_stall = '{0, 0, 64, 12};
    error_count     = 0;
    pixels_sent     = 0;
    results_checked = 0;
    gray_sent       = 0;
    gap_pct   = 0;
    stall_pct = 0;
    rst          <= 1'b1;
    pixel.valid  <= 1'b0;
    pixel.red    <= 8'd0;
    pixel.green  <= 8'd0;
    pixel.blue   <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pixel_rows[i]) begin
      send_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue,
                 pixel_rows[i].known, pixel_rows[i].hsl);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < RANDOM_PIXELS / NUM_PHASES; n++) begin
        pick_pixel(r, g, b);
        send_pixel(r, g, b, 1'b0, '0);
      end
      // Hold the input off until every pending result has come back.
      pixel.valid <= 1'b0;
      while (pending_hsl.size() != 0) @(posedge clk);
    end

    // Let any stray result show up before the verdict.
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d pixels (%0d gray) over four idling phases; %0d results checked.",
             pixels_sent, gray_sent, results_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net in case the block stops answering.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_hsl.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
